// ===== sv/polygon_mask_rasterizer_core_macros.svh =====
// Assertion macros shared by the polygon mask rasterizer RTL.
`ifndef POLYGON_MASK_RASTERIZER_CORE_MACROS_SVH
`define POLYGON_MASK_RASTERIZER_CORE_MACROS_SVH

// Same-cycle implication, sampled on clock, off during reset.
`define PMR_ASSERT_IMPL(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("pmr invariant violated");

// Next-cycle implication, sampled on clock, off during reset.
`define PMR_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("pmr sequence violated");

`endif

// ===== sv/pmr_pkg.sv =====
// Shared types and constants of the polygon mask rasterizer.
package pmr_pkg;

   localparam int COORD_W  = 13;            // vertex coordinate, signed
   localparam int PIX_W    = 12;            // pixel coordinate, unsigned
   localparam int COLOR_W  = 8;
   localparam int DIFF_W   = COORD_W + 1;   // coordinate differences
   localparam int PROD_W   = 2 * DIFF_W;    // signed product
   localparam int QUO_W    = 13;            // quotient / divisor magnitude
   localparam int NUM_W    = 2 * QUO_W;     // dividend magnitude
   localparam int CROSS_W  = DIFF_W + 1;    // crossing column
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DAT_W = 13;
   localparam int VCNT_W   = 5;
   localparam int ROI_POS_W = 12;
   localparam int ROI_LEN_W = 13;

   localparam logic ACT_LOAD  = 1'b0;
   localparam logic ACT_PIXEL = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_VERTEX_COUNT = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ROI_LEFT     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ROI_TOP      = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_ROI_WIDTH    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_ROI_HEIGHT   = 3'd4;

   localparam logic [COLOR_W-1:0] COLOR_FULL = 8'd255;
   localparam logic [COLOR_W-1:0] COLOR_NONE = 8'd0;

   // sideband that travels with one edge through the divider
   typedef struct packed {
      logic                      valid;
      logic                      last;
      logic                      straddle;
      logic                      neg;
      logic signed [COORD_W-1:0] xi;
   } pmr_tag_type;

   // edge issue control from the sequencer
   typedef struct packed {
      logic valid;
      logic last;
   } edge_ctl_type;

   // walk outcome back to the sequencer
   typedef struct packed {
      logic done;
      logic parity;
   } edge_res_type;

endpackage

// ===== sv/polygon_mask_rasterizer_core.sv =====
// Polygon mask rasterizer top: config, vertex memory, edge walk sequencer.
// Load item: busy stays low. Pixel outside the ROI or with no
// vertices: result in the cycle after the accept. Pixel in the ROI: result and
// next accept come after (n = used vertices) n + 1 reads
// on the single vertex memory port, the edge pipeline stages and the result register.
// Reset (synchronous) clears config, sequencer and strobes; vertex memory is not cleared.
`include "polygon_mask_rasterizer_core_macros.svh"

module polygon_mask_rasterizer_core #(
   parameter int MAX_VERTICES = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   output logic                                  busy,
   input  logic                                  req_action,
   input  logic [3:0]                            req_vertex_slot,
   input  logic signed [pmr_pkg::COORD_W-1:0]    req_vertex_col,
   input  logic signed [pmr_pkg::COORD_W-1:0]    req_vertex_row,
   input  logic [pmr_pkg::PIX_W-1:0]             req_pixel_col,
   input  logic [pmr_pkg::PIX_W-1:0]             req_pixel_row,
   input  logic [pmr_pkg::COLOR_W-1:0]           req_blue_in,
   input  logic [pmr_pkg::COLOR_W-1:0]           req_green_in,
   input  logic [pmr_pkg::COLOR_W-1:0]           req_red_in,
   input  logic                                  csr_we,
   input  logic [pmr_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [pmr_pkg::CSR_DAT_W-1:0]         csr_wdata,
   output logic                                  rsp_valid,
   output logic                                  rsp_inside_res,
   output logic [pmr_pkg::COLOR_W-1:0]           rsp_mask_byte,
   output logic [pmr_pkg::COLOR_W-1:0]           rsp_blue_out,
   output logic [pmr_pkg::COLOR_W-1:0]           rsp_green_out,
   output logic [pmr_pkg::COLOR_W-1:0]           rsp_red_out
);
   import pmr_pkg::*;

   localparam int AW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
   localparam int CW = $clog2(MAX_VERTICES + 2);
   localparam int MW = 2 * COORD_W;

   typedef enum logic [2:0] {
      S_IDLE = 3'b001,
      S_WALK = 3'b010,
      S_WAIT = 3'b100
   } state_type;

   // configuration
   logic [VCNT_W-1:0]    vcount_ff;
   logic [ROI_POS_W-1:0] roi_left_ff;
   logic [ROI_POS_W-1:0] roi_top_ff;
   logic [ROI_LEN_W-1:0] roi_width_ff;
   logic [ROI_LEN_W-1:0] roi_height_ff;

   // vertex memory, {x, y}
   logic [MW-1:0] vtx_mem [MAX_VERTICES];
   logic [MW-1:0] rd_data_ff;
   logic [MW-1:0] prev_ff;
   logic          rd_en;
   logic [AW-1:0] rd_addr;
   logic          rd_first;
   logic          rd_last;
   logic          rd_vld_ff;
   logic          rd_first_ff;
   logic          rd_last_ff;

   state_type     state_ff;
   state_type     state_in;
   logic [CW-1:0] iss_ff;
   logic [CW-1:0] iss_in;
   logic [CW-1:0] iss_m1;
   logic [CW-1:0] n_ff;
   logic [CW-1:0] n_m1;
   logic [CW-1:0] n_sat;

   logic [PIX_W-1:0]   px_col_ff;
   logic [PIX_W-1:0]   px_row_ff;
   logic [COLOR_W-1:0] blue_ff;
   logic [COLOR_W-1:0] green_ff;
   logic [COLOR_W-1:0] red_ff;

   logic                 accept;
   logic                 load_acc;
   logic                 pix_acc;
   logic                 slot_ok;
   logic [ROI_LEN_W-1:0] x_end;
   logic [ROI_LEN_W-1:0] y_end;
   logic                 roi_hit;

   edge_ctl_type edge_ctl;
   edge_res_type edge_res;

   logic               rsp_set;
   logic               rsp_inside_in;
   logic [COLOR_W-1:0] src_blue;
   logic [COLOR_W-1:0] src_green;
   logic [COLOR_W-1:0] src_red;
   logic               rsp_valid_ff;
   logic               rsp_inside_ff;
   logic [COLOR_W-1:0] rsp_blue_ff;
   logic [COLOR_W-1:0] rsp_green_ff;
   logic [COLOR_W-1:0] rsp_red_ff;

   assign busy     = (state_ff != S_IDLE);
   assign accept   = start & ~busy;
   assign load_acc = accept & (req_action == ACT_LOAD);
   assign pix_acc  = accept & (req_action == ACT_PIXEL);
   assign slot_ok  = (32'(req_vertex_slot) < 32'(MAX_VERTICES));

   assign x_end   = {1'b0, roi_left_ff} + roi_width_ff;
   assign y_end   = {1'b0, roi_top_ff} + roi_height_ff;
   assign roi_hit = (req_pixel_col >= roi_left_ff) && ({1'b0, req_pixel_col} < x_end) &&
                    (req_pixel_row >= roi_top_ff) && ({1'b0, req_pixel_row} < y_end);

   assign n_sat = (32'(vcount_ff) > 32'(MAX_VERTICES)) ? CW'(MAX_VERTICES) : CW'(vcount_ff);
   assign n_m1  = n_ff - 1'b1;
   assign iss_m1 = iss_ff - 1'b1;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         vcount_ff     <= '0;
         roi_left_ff   <= '0;
         roi_top_ff    <= '0;
         roi_width_ff  <= '0;
         roi_height_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_VERTEX_COUNT: vcount_ff     <= csr_wdata[VCNT_W-1:0];
            CSR_ROI_LEFT:     roi_left_ff   <= csr_wdata[ROI_POS_W-1:0];
            CSR_ROI_TOP:      roi_top_ff    <= csr_wdata[ROI_POS_W-1:0];
            CSR_ROI_WIDTH:    roi_width_ff  <= csr_wdata[ROI_LEN_W-1:0];
            CSR_ROI_HEIGHT:   roi_height_ff <= csr_wdata[ROI_LEN_W-1:0];
            default: ;
         endcase
      end
   end

   // vertex memory: write on load items, registered read during the walk
   always_ff @(posedge clock) begin
      if (load_acc && slot_ok) begin
         vtx_mem[AW'(req_vertex_slot)] <= {req_vertex_col, req_vertex_row};
      end
      if (rd_en) begin
         rd_data_ff <= vtx_mem[rd_addr];
      end
   end

   // walk: read vertex n-1 first, then 0..n-1, so each read pairs with the one before
   always_comb begin
      state_in      = state_ff;
      iss_in        = iss_ff;
      rd_en         = 1'b0;
      rd_first      = 1'b0;
      rd_last       = 1'b0;
      rd_addr       = '0;
      rsp_set       = 1'b0;
      rsp_inside_in = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (pix_acc) begin
               if (roi_hit && (n_sat != '0)) begin
                  state_in = S_WALK;
                  iss_in   = '0;
               end else begin
                  rsp_set = 1'b1;
               end
            end
         end
         S_WALK: begin
            rd_en    = 1'b1;
            rd_first = (iss_ff == '0);
            rd_last  = (iss_ff == n_ff);
            rd_addr  = rd_first ? n_m1[AW-1:0] : iss_m1[AW-1:0];
            iss_in   = iss_ff + 1'b1;
            if (rd_last) begin
               state_in = S_WAIT;
            end
         end
         S_WAIT: begin
            if (edge_res.done) begin
               rsp_set       = 1'b1;
               rsp_inside_in = edge_res.parity;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         iss_ff      <= '0;
         rd_vld_ff   <= 1'b0;
         rd_first_ff <= 1'b0;
         rd_last_ff  <= 1'b0;
      end else begin
         state_ff    <= state_in;
         iss_ff      <= iss_in;
         rd_vld_ff   <= rd_en;
         rd_first_ff <= rd_first;
         rd_last_ff  <= rd_last;
      end
   end

   always_ff @(posedge clock) begin
      if (pix_acc) begin
         n_ff      <= n_sat;
         px_col_ff <= req_pixel_col;
         px_row_ff <= req_pixel_row;
         blue_ff   <= req_blue_in;
         green_ff  <= req_green_in;
         red_ff    <= req_red_in;
      end
      if (rd_vld_ff) begin
         prev_ff <= rd_data_ff;
      end
   end

   assign edge_ctl.valid = rd_vld_ff & ~rd_first_ff;
   assign edge_ctl.last  = rd_last_ff;

   pmr_edge u_edge (
      .clock  (clock),
      .reset  (reset),
      .ctl    (edge_ctl),
      .xi     (rd_data_ff[MW-1:COORD_W]),
      .yi     (rd_data_ff[COORD_W-1:0]),
      .xj     (prev_ff[MW-1:COORD_W]),
      .yj     (prev_ff[COORD_W-1:0]),
      .px_col (px_col_ff),
      .px_row (px_row_ff),
      .res    (edge_res)
   );

   // fast path results take the color straight from the request
   assign src_blue  = (state_ff == S_IDLE) ? req_blue_in  : blue_ff;
   assign src_green = (state_ff == S_IDLE) ? req_green_in : green_ff;
   assign src_red   = (state_ff == S_IDLE) ? req_red_in   : red_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_set;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_set) begin
         rsp_inside_ff <= rsp_inside_in;
         rsp_blue_ff   <= rsp_inside_in ? COLOR_FULL : src_blue;
         rsp_green_ff  <= rsp_inside_in ? COLOR_FULL : src_green;
         rsp_red_ff    <= rsp_inside_in ? COLOR_NONE : src_red;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_inside_res = rsp_inside_ff;
   assign rsp_mask_byte  = rsp_inside_ff ? COLOR_FULL : COLOR_NONE;
   assign rsp_blue_out   = rsp_blue_ff;
   assign rsp_green_out  = rsp_green_ff;
   assign rsp_red_out    = rsp_red_ff;

   `PMR_ASSERT_IMPL(a_done_in_wait, edge_res.done, state_ff == S_WAIT)
   `PMR_ASSERT_IMPL(a_issue_bound, state_ff == S_WALK, iss_ff <= n_ff)
   `PMR_ASSERT_NEXT(a_walk_to_wait, (state_ff == S_WALK) && (iss_ff == n_ff),
                    state_ff == S_WAIT)

endmodule

// ===== sv/pmr_div.sv =====
// Pipelined restoring divider on magnitudes, one quotient bit per stage.
module pmr_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [pmr_pkg::NUM_W-1:0]     num,
   input  logic [pmr_pkg::QUO_W-1:0]     den,
   input  pmr_pkg::pmr_tag_type          tag_in,
   output logic [pmr_pkg::QUO_W-1:0]     quo,
   output pmr_pkg::pmr_tag_type          tag_out
);
   import pmr_pkg::*;

   logic [QUO_W-1:0] rem_q [QUO_W];
   logic [QUO_W-1:0] quo_q [QUO_W];
   logic [QUO_W-1:0] low_q [QUO_W];
   logic [QUO_W-1:0] den_q [QUO_W];
   pmr_tag_type      tag_q [QUO_W];

   // the quotient of a straddling edge stays below 2**QUO_W, so the upper
   // dividend half is already smaller than the divisor
   for (genvar s = 0; s < QUO_W; s++) begin : g_stage
      logic [QUO_W-1:0] rem_src;
      logic [QUO_W-1:0] quo_src;
      logic [QUO_W-1:0] low_src;
      logic [QUO_W-1:0] den_src;
      pmr_tag_type      tag_src;
      logic [QUO_W:0]   trial;
      logic [QUO_W:0]   diff;
      logic             ge;
      logic [QUO_W-1:0] rem_ff;
      logic [QUO_W-1:0] quo_ff;
      logic [QUO_W-1:0] low_ff;
      logic [QUO_W-1:0] den_ff;
      pmr_tag_type      tag_ff;

      if (s == 0) begin : g_first
         assign rem_src = num[NUM_W-1:QUO_W];
         assign low_src = num[QUO_W-1:0];
         assign quo_src = '0;
         assign den_src = den;
         assign tag_src = tag_in;
      end else begin : g_rest
         assign rem_src = rem_q[s-1];
         assign low_src = low_q[s-1];
         assign quo_src = quo_q[s-1];
         assign den_src = den_q[s-1];
         assign tag_src = tag_q[s-1];
      end

      assign trial = {rem_src, low_src[QUO_W-1-s]};
      assign ge    = (trial >= {1'b0, den_src});
      assign diff  = trial - {1'b0, den_src};

      always_ff @(posedge clock) begin
         rem_ff <= ge ? diff[QUO_W-1:0] : trial[QUO_W-1:0];
         quo_ff <= {quo_src[QUO_W-2:0], ge};
         low_ff <= low_src;
         den_ff <= den_src;
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            tag_ff <= '0;
         end else begin
            tag_ff <= tag_src;
         end
      end

      assign rem_q[s] = rem_ff;
      assign quo_q[s] = quo_ff;
      assign low_q[s] = low_ff;
      assign den_q[s] = den_ff;
      assign tag_q[s] = tag_ff;
   end

   assign quo     = quo_q[QUO_W-1];
   assign tag_out = tag_q[QUO_W-1];

endmodule

// ===== sv/pmr_edge.sv =====
// Edge pipeline: straddle test, product, divide, crossing compare, parity.
module pmr_edge (
   input  logic                              clock,
   input  logic                              reset,
   input  pmr_pkg::edge_ctl_type             ctl,
   input  logic signed [pmr_pkg::COORD_W-1:0] xi,
   input  logic signed [pmr_pkg::COORD_W-1:0] yi,
   input  logic signed [pmr_pkg::COORD_W-1:0] xj,
   input  logic signed [pmr_pkg::COORD_W-1:0] yj,
   input  logic [pmr_pkg::PIX_W-1:0]         px_col,
   input  logic [pmr_pkg::PIX_W-1:0]         px_row,
   output pmr_pkg::edge_res_type             res
);
   import pmr_pkg::*;

   logic signed [DIFF_W-1:0] y_s;
   logic signed [DIFF_W-1:0] dx_in;
   logic signed [DIFF_W-1:0] dyp_in;
   logic signed [DIFF_W-1:0] den_in;
   logic                     straddle;

   pmr_tag_type              s1_tag_ff;
   logic signed [DIFF_W-1:0] s1_dx_ff;
   logic signed [DIFF_W-1:0] s1_dyp_ff;
   logic signed [DIFF_W-1:0] s1_den_ff;

   pmr_tag_type              s2_tag_ff;
   logic signed [PROD_W-1:0] s2_prod_ff;
   logic signed [DIFF_W-1:0] s2_den_ff;

   logic signed [PROD_W-1:0] prod_neg;
   logic signed [DIFF_W-1:0] den_neg;
   pmr_tag_type              s3_tag_in;
   pmr_tag_type              s3_tag_ff;
   logic [NUM_W-1:0]         s3_num_ff;
   logic [QUO_W-1:0]         s3_den_ff;

   logic [QUO_W-1:0]          quo;
   pmr_tag_type               d_tag;
   logic signed [DIFF_W-1:0]  q_pos;
   logic signed [DIFF_W-1:0]  q_s;
   logic signed [CROSS_W-1:0] cross_col;
   logic signed [CROSS_W-1:0] x_s;
   logic                      hit;
   logic                      acc_ff;
   edge_res_type              res_ff;

   assign y_s      = $signed({2'b00, px_row});
   assign straddle = (DIFF_W'(yi) >= y_s) != (DIFF_W'(yj) >= y_s);
   assign dx_in    = DIFF_W'(xj) - DIFF_W'(xi);
   assign dyp_in   = y_s - DIFF_W'(yi);
   assign den_in   = DIFF_W'(yj) - DIFF_W'(yi);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_tag_ff <= '0;
         s2_tag_ff <= '0;
         s3_tag_ff <= '0;
      end else begin
         s1_tag_ff <= '{valid: ctl.valid, last: ctl.last, straddle: straddle,
                        neg: 1'b0, xi: xi};
         s2_tag_ff <= s1_tag_ff;
         s3_tag_ff <= s3_tag_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_dx_ff   <= dx_in;
      s1_dyp_ff  <= dyp_in;
      s1_den_ff  <= den_in;
      s2_prod_ff <= PROD_W'(s1_dx_ff) * PROD_W'(s1_dyp_ff);
      s2_den_ff  <= s1_den_ff;
   end

   // magnitudes; quotient sign follows C truncation toward zero
   assign prod_neg = -s2_prod_ff;
   assign den_neg  = -s2_den_ff;

   always_comb begin
      s3_tag_in     = s2_tag_ff;
      s3_tag_in.neg = s2_prod_ff[PROD_W-1] ^ s2_den_ff[DIFF_W-1];
   end

   always_ff @(posedge clock) begin
      s3_num_ff <= s2_prod_ff[PROD_W-1] ? prod_neg[NUM_W-1:0] : s2_prod_ff[NUM_W-1:0];
      s3_den_ff <= s2_den_ff[DIFF_W-1] ? den_neg[QUO_W-1:0] : s2_den_ff[QUO_W-1:0];
   end

   pmr_div u_div (
      .clock   (clock),
      .reset   (reset),
      .num     (s3_num_ff),
      .den     (s3_den_ff),
      .tag_in  (s3_tag_ff),
      .quo     (quo),
      .tag_out (d_tag)
   );

   assign q_pos     = $signed({1'b0, quo});
   assign q_s       = d_tag.neg ? -q_pos : q_pos;
   assign cross_col = CROSS_W'(q_s) + CROSS_W'(d_tag.xi);
   assign x_s       = $signed({3'b000, px_col});
   assign hit       = d_tag.straddle && (x_s <= cross_col);

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= 1'b0;
         res_ff <= '0;
      end else begin
         res_ff.done   <= d_tag.valid & d_tag.last;
         res_ff.parity <= acc_ff ^ hit;
         if (d_tag.valid) begin
            acc_ff <= d_tag.last ? 1'b0 : (acc_ff ^ hit);
         end
      end
   end

   assign res = res_ff;

endmodule

// ===== verif/polygon_mask_rasterizer_core_tb.sv =====
// Self-checking testbench for polygon_mask_rasterizer_core: directed table, then random polygons.
module polygon_mask_rasterizer_core_tb;
   import pmr_pkg::*;

   localparam int MAX_VERT    = 16;
   localparam int ITEM_TARGET = 900;
   localparam int DRAIN_GUARD = 40;
   localparam int STALL_LIMIT = 2000;
   localparam int REPORT_MAX  = 10;

   typedef struct packed {
      logic                      action;
      logic [3:0]                slot;
      logic signed [COORD_W-1:0] vcol;
      logic signed [COORD_W-1:0] vrow;
      logic [PIX_W-1:0]          pcol;
      logic [PIX_W-1:0]          prow;
      logic [COLOR_W-1:0]        blue;
      logic [COLOR_W-1:0]        green;
      logic [COLOR_W-1:0]        red;
   } raster_req_type;

   typedef struct packed {
      logic               in_poly;
      logic [COLOR_W-1:0] mask;
      logic [COLOR_W-1:0] blue;
      logic [COLOR_W-1:0] green;
      logic [COLOR_W-1:0] red;
   } raster_rsp_type;

   typedef enum logic {STEP_REG, STEP_ITEM} step_kind_type;

   typedef struct {
      step_kind_type        kind;
      logic [CSR_IDX_W-1:0] reg_idx;
      logic [CSR_DAT_W-1:0] reg_val;
      raster_req_type       item;
      bit                   fixed;
      raster_rsp_type       want;
   } plan_row_type;

   localparam raster_rsp_type INSIDE_RSP =
      '{1'b1, COLOR_FULL, COLOR_FULL, COLOR_FULL, COLOR_NONE};

   logic                      clock;
   logic                      reset;
   logic                      start;
   logic                      busy;
   logic                      req_action;
   logic [3:0]                req_vertex_slot;
   logic signed [COORD_W-1:0] req_vertex_col;
   logic signed [COORD_W-1:0] req_vertex_row;
   logic [PIX_W-1:0]          req_pixel_col;
   logic [PIX_W-1:0]          req_pixel_row;
   logic [COLOR_W-1:0]        req_blue_in;
   logic [COLOR_W-1:0]        req_green_in;
   logic [COLOR_W-1:0]        req_red_in;
   logic                      csr_we;
   logic [CSR_IDX_W-1:0]      csr_index;
   logic [CSR_DAT_W-1:0]      csr_wdata;
   logic                      rsp_valid;
   logic                      rsp_inside_res;
   logic [COLOR_W-1:0]        rsp_mask_byte;
   logic [COLOR_W-1:0]        rsp_blue_out;
   logic [COLOR_W-1:0]        rsp_green_out;
   logic [COLOR_W-1:0]        rsp_red_out;

   // local copy of the block state
   int                    vert_x [MAX_VERT];
   int                    vert_y [MAX_VERT];
   logic [VCNT_W-1:0]     cfg_count;
   logic [ROI_POS_W-1:0]  cfg_left;
   logic [ROI_POS_W-1:0]  cfg_top;
   logic [ROI_LEN_W-1:0]  cfg_width;
   logic [ROI_LEN_W-1:0]  cfg_height;

   raster_rsp_type pending_masks [$];
   plan_row_type   plan_q [$];
   bit             burst_mode;
   int             items_sent;
   int             directed_items;
   int             setups;
   int             results_seen;
   int             inside_seen;
   int             mismatches;

   polygon_mask_rasterizer_core #(.MAX_VERTICES(MAX_VERT)) DUT (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_action      (req_action),
      .req_vertex_slot (req_vertex_slot),
      .req_vertex_col  (req_vertex_col),
      .req_vertex_row  (req_vertex_row),
      .req_pixel_col   (req_pixel_col),
      .req_pixel_row   (req_pixel_row),
      .req_blue_in     (req_blue_in),
      .req_green_in    (req_green_in),
      .req_red_in      (req_red_in),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .rsp_valid       (rsp_valid),
      .rsp_inside_res  (rsp_inside_res),
      .rsp_mask_byte   (rsp_mask_byte),
      .rsp_blue_out    (rsp_blue_out),
      .rsp_green_out   (rsp_green_out),
      .rsp_red_out     (rsp_red_out)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic int clamp(input int v, input int lo, input int hi);
      if (v < lo) return lo;
      if (v > hi) return hi;
      return v;
   endfunction

   // even-odd crossing test over the edges in use, gated by the ROI
   function automatic raster_rsp_type shade_pixel(input raster_req_type it);
      int  n;
      int  j;
      int  x;
      int  y;
      int  cross_x;
      bit  hit;
      x   = int'(it.pcol);
      y   = int'(it.prow);
      n   = (cfg_count > MAX_VERT) ? MAX_VERT : int'(cfg_count);
      hit = 1'b0;
      if (x >= int'(cfg_left) && x < int'(cfg_left) + int'(cfg_width) &&
          y >= int'(cfg_top) && y < int'(cfg_top) + int'(cfg_height)) begin
         j = n - 1;
         for (int i = 0; i < n; i++) begin
            // horizontal edges never straddle, so the divisor is nonzero here
            if ((vert_y[i] >= y) != (vert_y[j] >= y)) begin
               cross_x = (vert_x[j] - vert_x[i]) * (y - vert_y[i]) / (vert_y[j] - vert_y[i])
                         + vert_x[i];
               if (x <= cross_x) hit = !hit;
            end
            j = i;
         end
      end
      if (hit) return INSIDE_RSP;
      return '{1'b0, COLOR_NONE, it.blue, it.green, it.red};
   endfunction

   function automatic raster_req_type load_req(input int slot, input int col, input int row);
      raster_req_type it;
      it        = '0;
      it.action = ACT_LOAD;
      it.slot   = 4'(slot);
      it.vcol   = COORD_W'(col);
      it.vrow   = COORD_W'(row);
      return it;
   endfunction

   function automatic raster_req_type pixel_req(input int x, input int y,
                                                input int b, input int g, input int r);
      raster_req_type it;
      it        = '0;
      it.action = ACT_PIXEL;
      it.pcol   = PIX_W'(x);
      it.prow   = PIX_W'(y);
      it.blue   = COLOR_W'(b);
      it.green  = COLOR_W'(g);
      it.red    = COLOR_W'(r);
      return it;
   endfunction

   function automatic void add_reg(input logic [CSR_IDX_W-1:0] idx, input int val);
      plan_row_type row;
      row.kind    = STEP_REG;
      row.reg_idx = idx;
      row.reg_val = CSR_DAT_W'(val);
      row.item    = '0;
      row.fixed   = 1'b0;
      row.want    = '0;
      plan_q.insert(plan_q.size(), row);
   endfunction

   function automatic void add_item(input raster_req_type it, input bit fixed,
                                    input raster_rsp_type want);
      plan_row_type row;
      row.kind    = STEP_ITEM;
      row.reg_idx = '0;
      row.reg_val = '0;
      row.item    = it;
      row.fixed   = fixed;
      row.want    = want;
      plan_q.insert(plan_q.size(), row);
   endfunction

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DAT_W-1:0] val);
      @(negedge clock);
      csr_we    = 1'b1;
      csr_index = idx;
      csr_wdata = val;
      @(negedge clock);
      csr_we = 1'b0;
      case (idx)
         CSR_VERTEX_COUNT: cfg_count  = val[VCNT_W-1:0];
         CSR_ROI_LEFT:     cfg_left   = val[ROI_POS_W-1:0];
         CSR_ROI_TOP:      cfg_top    = val[ROI_POS_W-1:0];
         CSR_ROI_WIDTH:    cfg_width  = val[ROI_LEN_W-1:0];
         CSR_ROI_HEIGHT:   cfg_height = val[ROI_LEN_W-1:0];
         default: ;
      endcase
   endtask

   // registers change only with nothing in flight
   task automatic wait_drained();
      @(negedge clock);
      start = 1'b0;
      while (pending_masks.size() != 0 || busy) @(posedge clock);
      repeat (DRAIN_GUARD) @(posedge clock);
   endtask

   task automatic send_item(input raster_req_type it, input bit fixed,
                            input raster_rsp_type want);
      int gap;
      @(negedge clock);
      start           = 1'b1;
      req_action      = it.action;
      req_vertex_slot = it.slot;
      req_vertex_col  = it.vcol;
      req_vertex_row  = it.vrow;
      req_pixel_col   = it.pcol;
      req_pixel_row   = it.prow;
      req_blue_in     = it.blue;
      req_green_in    = it.green;
      req_red_in      = it.red;
      do @(posedge clock); while (busy);
      items_sent++;
      if (it.action == ACT_LOAD) begin
         vert_x[it.slot] = int'($signed(it.vcol));
         vert_y[it.slot] = int'($signed(it.vrow));
      end else begin
         pending_masks.insert(pending_masks.size(), fixed ? want : shade_pixel(it));
      end
      gap = burst_mode ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
         @(negedge clock);
         start = 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
   endtask

   task automatic run_setup();
      int                   n_raw;
      int                   n_eff;
      int                   cx;
      int                   cy;
      int                   span;
      int                   npix;
      int                   pick;
      int                   v;
      int                   r_left;
      int                   r_top;
      int                   r_wid;
      int                   r_hgt;
      raster_req_type       it;
      wait_drained();
      pick = $urandom_range(0, 19);
      if (pick < 2)       n_raw = $urandom_range(0, 2);
      else if (pick < 17) n_raw = $urandom_range(3, 16);
      else                n_raw = $urandom_range(17, 31);
      n_eff = (n_raw > MAX_VERT) ? MAX_VERT : n_raw;
      cx    = $urandom_range(0, 4095);
      cy    = $urandom_range(0, 4095);
      span  = ($urandom_range(0, 4) == 0) ? $urandom_range(64, 4096) : $urandom_range(2, 48);
      case ($urandom_range(0, 9))
         0, 1, 2, 3: begin
            r_left = 0;  r_top = 0;  r_wid = 4096;  r_hgt = 4096;
         end
         4, 5, 6: begin
            r_left = clamp(cx - span, 0, 4095);
            r_top  = clamp(cy - span, 0, 4095);
            r_wid  = clamp(2 * span + 1, 0, 4096);
            r_hgt  = clamp(2 * span + 1, 0, 4096);
         end
         7: begin
            r_left = $urandom_range(0, 4095);  r_top = $urandom_range(0, 4095);
            r_wid  = $urandom_range(0, 4096);  r_hgt = $urandom_range(0, 4096);
         end
         8: begin
            // right/bottom bound past the pixel range
            r_left = $urandom_range(3900, 4095);  r_top = $urandom_range(3900, 4095);
            r_wid  = 4096;                        r_hgt = 4096;
         end
         default: begin
            r_left = 0;  r_top = 0;
            r_wid  = $urandom_range(0, 1) ? 0 : 4096;
            r_hgt  = (r_wid == 0) ? 4096 : 0;
         end
      endcase
      write_reg(CSR_VERTEX_COUNT, CSR_DAT_W'(n_raw));
      write_reg(CSR_ROI_LEFT,     CSR_DAT_W'(r_left));
      write_reg(CSR_ROI_TOP,      CSR_DAT_W'(r_top));
      write_reg(CSR_ROI_WIDTH,    CSR_DAT_W'(r_wid));
      write_reg(CSR_ROI_HEIGHT,   CSR_DAT_W'(r_hgt));
      burst_mode = ($urandom_range(0, 3) == 0);
      setups++;

      // polygon first, so no pixel walks an unwritten slot
      for (int k = 0; k < n_eff; k++) begin
         if ($urandom_range(0, 9) == 0)
            it = load_req(k, int'($urandom_range(0, 8191)) - 4096,
                          int'($urandom_range(0, 8191)) - 4096);
         else
            it = load_req(k, clamp(cx + int'($urandom_range(0, 2 * span)) - span, -4096, 4095),
                          clamp(cy + int'($urandom_range(0, 2 * span)) - span, -4096, 4095));
         it.pcol = PIX_W'($urandom);    it.prow  = PIX_W'($urandom);
         it.blue = COLOR_W'($urandom);  it.green = COLOR_W'($urandom);
         it.red  = COLOR_W'($urandom);
         send_item(it, 1'b0, '0);
      end

      npix = $urandom_range(16, 40);
      for (int k = 0; k < npix; k++) begin
         pick = $urandom_range(0, 19);
         if (pick == 0) begin
            it = load_req($urandom_range(0, 15), int'($urandom_range(0, 8191)) - 4096,
                          int'($urandom_range(0, 8191)) - 4096);
         end else if (pick < 3) begin
            it = pixel_req($urandom_range(0, 4095), $urandom_range(0, 4095),
                           $urandom_range(0, 255), $urandom_range(0, 255),
                           $urandom_range(0, 255));
         end else if (pick < 7 && n_eff > 0) begin
            // land on or next to a vertex to hit edge and corner rows
            v  = $urandom_range(0, n_eff - 1);
            it = pixel_req(clamp(vert_x[v] + int'($urandom_range(0, 2)) - 1, 0, 4095),
                           clamp(vert_y[v] + int'($urandom_range(0, 2)) - 1, 0, 4095),
                           $urandom_range(0, 255), $urandom_range(0, 255),
                           $urandom_range(0, 255));
         end else begin
            it = pixel_req(clamp(cx + int'($urandom_range(0, 2 * span)) - span, 0, 4095),
                           clamp(cy + int'($urandom_range(0, 2 * span)) - span, 0, 4095),
                           $urandom_range(0, 255), $urandom_range(0, 255),
                           $urandom_range(0, 255));
         end
         if (it.action == ACT_LOAD) begin
            it.pcol = PIX_W'($urandom);  it.prow = PIX_W'($urandom);
         end else begin
            it.slot = 4'($urandom);
            it.vcol = COORD_W'($urandom);  it.vrow = COORD_W'($urandom);
         end
         send_item(it, 1'b0, '0);
      end
   endtask

   always @(posedge clock) begin : check_results
      raster_rsp_type got;
      raster_rsp_type want;
      if (!reset && rsp_valid) begin
         got = '{rsp_inside_res, rsp_mask_byte, rsp_blue_out, rsp_green_out, rsp_red_out};
         results_seen++;
         if (got.in_poly) inside_seen++;
         if (pending_masks.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_MAX)
               $display("unexpected result: inside=%0d mask=%0d bgr=%0d,%0d,%0d",
                        got.in_poly, got.mask, got.blue, got.green, got.red);
         end else begin
            want = pending_masks.pop_front();
            if (got.in_poly !== want.in_poly || got.mask !== want.mask ||
                got.blue !== want.blue || got.green !== want.green ||
                got.red !== want.red) begin
               mismatches++;
               if (mismatches <= REPORT_MAX)
                  $display({"mismatch result %0d: exp inside=%0d mask=%0d bgr=%0d,%0d,%0d,",
                            " got inside=%0d mask=%0d bgr=%0d,%0d,%0d"},
                           results_seen, want.in_poly, want.mask, want.blue, want.green,
                           want.red, got.in_poly, got.mask, got.blue, got.green, got.red);
            end
         end
      end
   end

   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if (reset || (start && !busy) || rsp_valid || csr_we) quiet = 0;
         else quiet++;
      end
      $display("FAIL");
      $finish;
   end

   initial begin
      reset           = 1'b1;
      start           = 1'b0;
      req_action      = ACT_LOAD;
      req_vertex_slot = '0;
      req_vertex_col  = '0;
      req_vertex_row  = '0;
      req_pixel_col   = '0;
      req_pixel_row   = '0;
      req_blue_in     = '0;
      req_green_in    = '0;
      req_red_in      = '0;
      csr_we          = 1'b0;
      csr_index       = CSR_VERTEX_COUNT;
      csr_wdata       = '0;
      cfg_count       = '0;
      cfg_left        = '0;
      cfg_top         = '0;
      cfg_width       = '0;
      cfg_height      = '0;
      burst_mode      = 1'b0;
      items_sent      = 0;
      setups          = 0;
      results_seen    = 0;
      inside_seen     = 0;
      mismatches      = 0;
      for (int k = 0; k < MAX_VERT; k++) begin
         vert_x[k] = 0;
         vert_y[k] = 0;
      end
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // empty ROI after reset: everything outside, color passes through
      add_item(pixel_req(0, 0, 8'h12, 8'h34, 8'h56), 1'b1,
               '{1'b0, COLOR_NONE, 8'h12, 8'h34, 8'h56});
      add_item(pixel_req(4095, 4095, 255, 0, 255), 1'b1,
               '{1'b0, COLOR_NONE, 8'd255, 8'd0, 8'd255});
      // axis-aligned square, pixels on edges and on horizontal-edge rows
      add_item(load_req(0, 100, 100), 1'b0, '0);
      add_item(load_req(1, 300, 100), 1'b0, '0);
      add_item(load_req(2, 300, 300), 1'b0, '0);
      add_item(load_req(3, 100, 300), 1'b0, '0);
      add_reg(CSR_VERTEX_COUNT, 4);
      add_reg(CSR_ROI_LEFT, 0);
      add_reg(CSR_ROI_TOP, 0);
      add_reg(CSR_ROI_WIDTH, 4096);
      add_reg(CSR_ROI_HEIGHT, 4096);
      add_item(pixel_req(200, 200, 1, 2, 3), 1'b1, INSIDE_RSP);
      add_item(pixel_req(50, 200, 0, 255, 0), 1'b0, '0);
      add_item(pixel_req(100, 200, 9, 9, 9), 1'b0, '0);
      add_item(pixel_req(300, 200, 9, 9, 9), 1'b0, '0);
      add_item(pixel_req(200, 100, 7, 7, 7), 1'b0, '0);
      add_item(pixel_req(200, 300, 7, 7, 7), 1'b0, '0);
      // triangle on the coordinate extremes
      add_item(load_req(0, -4096, -4096), 1'b0, '0);
      add_item(load_req(1, 4095, 4095), 1'b0, '0);
      add_item(load_req(2, -4096, 4095), 1'b0, '0);
      add_reg(CSR_VERTEX_COUNT, 3);
      add_item(pixel_req(0, 0, 255, 255, 255), 1'b0, '0);
      add_item(pixel_req(0, 4095, 0, 0, 0), 1'b0, '0);
      add_item(pixel_req(4095, 0, 128, 64, 32), 1'b0, '0);
      // ROI ends past the pixel range: sums must not wrap
      add_reg(CSR_ROI_LEFT, 4095);
      add_reg(CSR_ROI_TOP, 4095);
      add_item(pixel_req(4095, 4095, 5, 6, 7), 1'b0, '0);
      add_item(pixel_req(4094, 4095, 5, 6, 7), 1'b1, '{1'b0, COLOR_NONE, 8'd5, 8'd6, 8'd7});
      // degenerate polygons
      add_reg(CSR_ROI_LEFT, 0);
      add_reg(CSR_ROI_TOP, 0);
      add_reg(CSR_VERTEX_COUNT, 2);
      add_item(pixel_req(0, 100, 11, 22, 33), 1'b0, '0);
      add_reg(CSR_VERTEX_COUNT, 0);
      add_item(pixel_req(0, 4000, 44, 55, 66), 1'b1, '{1'b0, COLOR_NONE, 8'd44, 8'd55, 8'd66});

      foreach (plan_q[i]) begin
         if (plan_q[i].kind == STEP_REG) begin
            if (i == 0 || plan_q[i-1].kind != STEP_REG) wait_drained();
            write_reg(plan_q[i].reg_idx, plan_q[i].reg_val);
         end else begin
            send_item(plan_q[i].item, plan_q[i].fixed, plan_q[i].want);
         end
      end
      directed_items = items_sent;

      while (items_sent < ITEM_TARGET) run_setup();
      wait_drained();
      mismatches += pending_masks.size();

      $display("Ran %0d items (%0d from the directed table) over %0d random polygon setups.",
               items_sent, directed_items, setups);
      $display("Checked %0d mask results, %0d of them inside the polygon.",
               results_seen, inside_seen);
      if (mismatches == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
